// File: rtl/kst_pkg.sv
// shared types and constants of the key state tracker
`timescale 1ns / 1ps
`default_nettype none
package kst_pkg;

	localparam int KEY_W = 6;
	localparam int KNUM_W = 7;
	localparam int CNT_W = 8;
	localparam int PEND_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [PEND_W-1:0] PEND_MAX = 4'hF;

	typedef enum logic [1:0] {
		ACT_PRESS   = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_TICK    = 2'd2,
		ACT_NOP     = 2'd3
	} kst_action_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_TAP     = 2'd1,
		EV_REPEAT  = 2'd2,
		EV_RELEASE = 2'd3
	} kst_event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RPT_DLY       = 2'd0,
		REG_KEY_COUNT     = 2'd1,
		REG_FIRST_NONTEXT = 2'd2,
		REG_IDLE_MASK     = 2'd3
	} kst_reg_t;

	typedef struct packed {
		logic             tap;
		logic             held;
		logic             rel;
		logic [CNT_W-1:0] cnt;
	} kst_flags_t;

	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [KEY_W-1:0] key;
	} kst_set_cmd_t;

endpackage
`default_nettype wire

// File: rtl/kst_flag_ram.sv
// per-key flag memory with registered read and per-entry valid bits
`timescale 1ns / 1ps
`default_nettype none
module kst_flag_ram import kst_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        we,
	input  wire logic [AW-1:0] wr_addr,
	input  wire kst_flags_t  wr_data,
	input  wire logic [AW-1:0] rd_addr,
	output kst_flags_t       rd_data
);

	kst_flags_t mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	kst_flags_t rd_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	// entries never written read as all zero
	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule
`default_nettype wire

// File: rtl/kst_key_set.sv
// ordered set of pressed keys with insert, remove and indexed read
`timescale 1ns / 1ps
`default_nettype none
module kst_key_set import kst_pkg::*; #(
	parameter int SET_DEPTH = 8,
	parameter int CW = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire kst_set_cmd_t     cmd,
	input  wire logic [CW-1:0]    rd_idx,
	output logic [KEY_W-1:0]      rd_key,
	output logic [CW-1:0]         count
);

	localparam int IW = $clog2(SET_DEPTH);

	logic [KEY_W-1:0] set_q [SET_DEPTH];
	logic [KEY_W-1:0] upper [SET_DEPTH];
	logic [CW-1:0] count_q;
	logic [SET_DEPTH-1:0] hit;
	logic [SET_DEPTH-1:0] shift;
	logic seen;
	logic do_ins;
	logic do_rem;

	always_comb begin
		seen = 1'b0;
		for (int i = 0; i < SET_DEPTH; i++) begin
			hit[i] = (CW'(i) < count_q) && (set_q[i] == cmd.key);
			seen = seen | hit[i];
			shift[i] = seen;
		end
		for (int i = 0; i < SET_DEPTH - 1; i++) begin
			upper[i] = set_q[i+1];
		end
		upper[SET_DEPTH-1] = '0;
	end

	assign do_ins = cmd.ins && !seen && (count_q < CW'(SET_DEPTH));
	assign do_rem = cmd.rem && seen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < SET_DEPTH; i++) begin
				set_q[i] <= '0;
			end
		end else if (do_ins) begin
			set_q[count_q[IW-1:0]] <= cmd.key;
			count_q <= count_q + 1'b1;
		end else if (do_rem) begin
			// close the gap left by the removed key
			for (int i = 0; i < SET_DEPTH; i++) begin
				if (shift[i] && (CW'(i + 1) < count_q)) begin
					set_q[i] <= upper[i];
				end else if (shift[i] && (CW'(i + 1) == count_q)) begin
					set_q[i] <= '0;
				end
			end
			count_q <= count_q - 1'b1;
		end
	end

	assign rd_key = (rd_idx < CW'(SET_DEPTH)) ? set_q[rd_idx[IW-1:0]] : '0;
	assign count = count_q;

endmodule
`default_nettype wire

// File: rtl/kst_flag_alu.sv
// shared flag update unit for press, release and frame tick steps
`timescale 1ns / 1ps
`default_nettype none
module kst_flag_alu import kst_pkg::*; (
	input  wire kst_action_t        action,
	input  wire kst_flags_t         f_in,
	input  wire logic [KEY_W-1:0]   key,
	input  wire logic [CNT_W-1:0]   rpt_dly,
	input  wire logic [KNUM_W-1:0]  first_non_text_key,
	input  wire logic               rep_in,
	input  wire logic               idle_bit,
	output kst_flags_t              f_out,
	output kst_event_t              kind,
	output logic                    rep_out,
	output logic                    inc
);

	logic non_text;
	logic rep;

	assign non_text = {1'b0, key} >= first_non_text_key;
	assign rep = rep_in | (f_in.cnt == rpt_dly);

	always_comb begin
		f_out = f_in;
		kind = EV_NONE;
		rep_out = rep_in;
		inc = 1'b0;
		unique case (action)
			ACT_PRESS: begin
				f_out.tap = !f_in.held || non_text;
				kind = f_out.tap ? EV_TAP : EV_NONE;
			end
			ACT_RELEASE: begin
				f_out.tap = 1'b0;
				f_out.held = 1'b0;
				f_out.rel = 1'b1;
				f_out.cnt = '0;
				kind = EV_RELEASE;
			end
			ACT_TICK: begin
				rep_out = rep;
				inc = (f_in.tap || f_in.held || f_in.rel) && !idle_bit;
				kind = (f_in.held && rep) ? EV_REPEAT : EV_NONE;
				f_out.cnt = (f_in.cnt < rpt_dly) ? f_in.cnt + 1'b1 : f_in.cnt;
				f_out.rel = 1'b0;
				f_out.tap = f_in.held ? 1'b0 : f_in.tap;
				f_out.held = f_out.tap | f_in.held;
				if (non_text && rep) begin
					f_out.tap = 1'b1;
					f_out.cnt = '0;
				end
			end
			ACT_NOP: begin
				f_out = f_in;
			end
			default: begin
				f_out = f_in;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/key_state_autorepeat_tracker_core.sv
// key state and autorepeat tracker, top level
// input channel (in_valid/in_ready) carries one action: press, release or frame tick,
// with a 1-based key number. output channel (out_valid/out_ready) carries result items,
// each with an event kind, the key, its flags, the pending event count and a last flag.
// config channel (cfg_valid/cfg_ready, always ready) writes one register per transfer:
// repeat delay, key count, first non-text key, idle hold mask.
// a press or release goes through the flag update state and then the single-result state
// to the output register; an ignored key or an empty tick skips the flag update state.
// a tick over N pressed keys walks the set through the shared flag unit, one flag memory
// access per cycle, then sends N results at one per cycle while the receiver takes them.
// one item is in flight at a time; in_ready is high only while the sequencer is idle.
// results sit in an output register, so a new item is taken while the last result of
// the previous one still waits; a stalled receiver holds further results in place.
// reset clears all key flags, the pressed set and the pending count, and loads the
// register defaults; the block accepts items in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module key_state_autorepeat_tracker_core import kst_pkg::*; #(
	parameter int MAX_KEYS = 64,
	parameter int SET_DEPTH = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            action,
	input  wire logic [KNUM_W-1:0]     key,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [1:0]                 event_kind,
	output logic [KEY_W-1:0]           event_key,
	output logic                       key_tap,
	output logic                       key_held,
	output logic                       key_released,
	output logic [PEND_W-1:0]          pending_events,
	output logic                       last,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CW = $clog2(SET_DEPTH + 1);
	localparam int IW = $clog2(SET_DEPTH);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PR    = 5'b00010,
		S_TWALK = 5'b00100,
		S_EMIT  = 5'b01000,
		S_ONE   = 5'b10000
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0] rpt_dly_q;
	logic [KNUM_W-1:0] key_count_q;
	logic [KNUM_W-1:0] first_nt_q;
	logic [CFG_DATA_W-1:0] idle_mask_q;

	kst_action_t act_q;
	logic [KEY_W-1:0] cur_key_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] e_q;
	logic [CW-1:0] n_q;
	logic rep_q;
	logic [PEND_W-1:0] tot_q;
	logic [PEND_W-1:0] evt_total_q;

	kst_event_t one_kind_q;
	logic [KEY_W-1:0] one_key_q;
	logic [2:0] one_flags_q;

	kst_event_t buf_kind_q [SET_DEPTH];
	logic [KEY_W-1:0] buf_key_q [SET_DEPTH];
	logic [2:0] buf_flags_q [SET_DEPTH];

	logic out_valid_q;
	kst_event_t out_kind_q;
	logic [KEY_W-1:0] out_key_q;
	logic [2:0] out_flags_q;
	logic [PEND_W-1:0] out_pend_q;
	logic out_last_q;

	logic accept;
	logic out_free;
	logic out_load;
	logic [KNUM_W-1:0] limit;
	logic [KNUM_W-1:0] key_m1;
	logic ignore;
	logic [KEY_W-1:0] rd_key_sel;
	logic [CW-1:0] set_rd_idx;
	logic [KEY_W-1:0] set_rd_key;
	logic [CW-1:0] set_count;
	kst_set_cmd_t set_cmd;
	kst_flags_t ram_rd;
	logic ram_we;

	kst_flags_t alu_f;
	kst_event_t alu_kind;
	logic alu_rep;
	logic alu_inc;
	logic [PEND_W-1:0] tot_n;
	logic walk_done;
	logic emit_last;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || out_ready;
	assign out_load = out_free && ((state_q == S_EMIT) || (state_q == S_ONE));

	assign limit = (key_count_q < KNUM_W'(MAX_KEYS)) ? key_count_q : KNUM_W'(MAX_KEYS);
	assign key_m1 = key - 1'b1;
	assign ignore = (kst_action_t'(action) == ACT_NOP) || (key == '0) || (key > limit);

	// read index into the pressed set: head on tick start, next key while walking
	assign set_rd_idx = (state_q == S_TWALK) ? j_q + 1'b1 : '0;
	assign rd_key_sel = (state_q == S_IDLE && kst_action_t'(action) != ACT_TICK) ?
		key_m1[KEY_W-1:0] : set_rd_key;

	assign ram_we = (state_q == S_PR) || (state_q == S_TWALK);
	assign set_cmd.ins = (state_q == S_PR) && (act_q == ACT_PRESS);
	assign set_cmd.rem = (state_q == S_PR) && (act_q == ACT_RELEASE);
	assign set_cmd.key = cur_key_q;

	assign tot_n = (alu_inc && tot_q != PEND_MAX) ? tot_q + 1'b1 : tot_q;
	assign walk_done = (j_q + 1'b1) == n_q;
	assign emit_last = (e_q + 1'b1) == n_q;

	kst_flag_ram #(
		.DEPTH (MAX_KEYS),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (ram_we),
		.wr_addr (cur_key_q[AW-1:0]),
		.wr_data (alu_f),
		.rd_addr (rd_key_sel[AW-1:0]),
		.rd_data (ram_rd)
	);

	kst_key_set #(
		.SET_DEPTH (SET_DEPTH),
		.CW        (CW)
	) u_set (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (set_cmd),
		.rd_idx (set_rd_idx),
		.rd_key (set_rd_key),
		.count  (set_count)
	);

	kst_flag_alu u_alu (
		.action             (act_q),
		.f_in               (ram_rd),
		.key                (cur_key_q),
		.rpt_dly            (rpt_dly_q),
		.first_non_text_key (first_nt_q),
		.rep_in             (rep_q),
		.idle_bit           (idle_mask_q[cur_key_q]),
		.f_out              (alu_f),
		.kind               (alu_kind),
		.rep_out            (alu_rep),
		.inc                (alu_inc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_dly_q <= 8'd4;
			key_count_q <= 7'd64;
			first_nt_q <= 7'd64;
			idle_mask_q <= '0;
		end else if (cfg_valid) begin
			unique case (kst_reg_t'(cfg_index))
				REG_RPT_DLY:       rpt_dly_q <= cfg_data[CNT_W-1:0];
				REG_KEY_COUNT:     key_count_q <= cfg_data[KNUM_W-1:0];
				REG_FIRST_NONTEXT: first_nt_q <= cfg_data[KNUM_W-1:0];
				REG_IDLE_MASK:     idle_mask_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_q <= ACT_NOP;
			cur_key_q <= '0;
			j_q <= '0;
			e_q <= '0;
			n_q <= '0;
			rep_q <= 1'b0;
			tot_q <= '0;
			evt_total_q <= '0;
			one_kind_q <= EV_NONE;
			one_key_q <= '0;
			one_flags_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						act_q <= kst_action_t'(action);
						if (kst_action_t'(action) == ACT_TICK) begin
							if (set_count == '0) begin
								evt_total_q <= '0;
								one_kind_q <= EV_NONE;
								one_key_q <= '0;
								one_flags_q <= '0;
								state_q <= S_ONE;
							end else begin
								cur_key_q <= set_rd_key;
								j_q <= '0;
								n_q <= set_count;
								rep_q <= 1'b0;
								tot_q <= '0;
								state_q <= S_TWALK;
							end
						end else if (ignore) begin
							one_kind_q <= EV_NONE;
							one_key_q <= '0;
							one_flags_q <= '0;
							state_q <= S_ONE;
						end else begin
							cur_key_q <= key_m1[KEY_W-1:0];
							state_q <= S_PR;
						end
					end
				end
				S_PR: begin
					one_kind_q <= alu_kind;
					one_key_q <= cur_key_q;
					one_flags_q <= {alu_f.tap, alu_f.held, alu_f.rel};
					state_q <= S_ONE;
				end
				S_TWALK: begin
					rep_q <= alu_rep;
					tot_q <= tot_n;
					cur_key_q <= set_rd_key;
					j_q <= j_q + 1'b1;
					if (walk_done) begin
						evt_total_q <= tot_n;
						e_q <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						e_q <= e_q + 1'b1;
						if (emit_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_ONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// per-key results of a tick, sent once the pending count is final
	always_ff @(posedge clk) begin
		if (state_q == S_TWALK) begin
			buf_kind_q[j_q[IW-1:0]] <= alu_kind;
			buf_key_q[j_q[IW-1:0]] <= cur_key_q;
			buf_flags_q[j_q[IW-1:0]] <= {alu_f.tap, alu_f.held, alu_f.rel};
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			out_kind_q <= buf_kind_q[e_q[IW-1:0]];
			out_key_q <= buf_key_q[e_q[IW-1:0]];
			out_flags_q <= buf_flags_q[e_q[IW-1:0]];
			out_pend_q <= evt_total_q;
			out_last_q <= emit_last;
		end else if (state_q == S_ONE && out_free) begin
			out_kind_q <= one_kind_q;
			out_key_q <= one_key_q;
			out_flags_q <= one_flags_q;
			out_pend_q <= evt_total_q;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign event_kind = out_kind_q;
	assign event_key = out_key_q;
	assign key_tap = out_flags_q[2];
	assign key_held = out_flags_q[1];
	assign key_released = out_flags_q[0];
	assign pending_events = out_pend_q;
	assign last = out_last_q;

endmodule
`default_nettype wire

// File: tb/sv/key_state_autorepeat_tracker_core_test.sv
// self-checking testbench of the key state and autorepeat tracker core
`timescale 1ns / 1ps
module key_state_autorepeat_tracker_core_test;
	import kst_pkg::*;

	localparam int MAX_KEYS = 64;
	localparam int SET_DEPTH = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD = 400;
	localparam int DIR_ROWS = 25;

	typedef struct packed {
		kst_event_t        kind;
		logic [KEY_W-1:0]  ekey;
		logic              tap;
		logic              held;
		logic              rel;
		logic [PEND_W-1:0] pend;
		logic              tail;
	} key_result_t;

	typedef struct packed {
		kst_action_t       act;
		logic [KNUM_W-1:0] knum;
		logic              fixed;
		key_result_t       res;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] action;
	logic [KNUM_W-1:0] key;
	logic out_valid;
	logic out_ready;
	logic [1:0] event_kind;
	logic [KEY_W-1:0] event_key;
	logic key_tap;
	logic key_held;
	logic key_released;
	logic [PEND_W-1:0] pending_events;
	logic last;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	key_state_autorepeat_tracker_core #(
		.MAX_KEYS(MAX_KEYS),
		.SET_DEPTH(SET_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.key(key),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_kind(event_kind),
		.event_key(event_key),
		.key_tap(key_tap),
		.key_held(key_held),
		.key_released(key_released),
		.pending_events(pending_events),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// tracker state
	logic m_tap [MAX_KEYS];
	logic m_held [MAX_KEYS];
	logic m_rel [MAX_KEYS];
	logic [CNT_W-1:0] m_hold [MAX_KEYS];
	logic [KEY_W-1:0] press_order [$];
	logic [PEND_W-1:0] ev_total;
	logic [7:0] rpt_delay;
	logic [KNUM_W-1:0] key_limit_reg;
	logic [KNUM_W-1:0] first_nt;
	logic [63:0] idle_mask;

	key_result_t key_event_q [$];
	key_result_t got;
	key_result_t want;
	dir_row_t dir_tab [DIR_ROWS];

	int n_bad = 0;
	int n_results = 0;
	int n_items = 0;
	int n_repeat = 0;
	int n_full_press = 0;
	int n_ignored = 0;
	int n_settings = 0;
	int n_cycles = 0;
	int burst_left = 0;
	int hot_lo = 1;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void set_reg(input kst_reg_t r, input logic [63:0] d);
		case (r)
			REG_RPT_DLY: rpt_delay = d[7:0];
			REG_KEY_COUNT: key_limit_reg = d[6:0];
			REG_FIRST_NONTEXT: first_nt = d[6:0];
			default: idle_mask = d;
		endcase
	endfunction

	function automatic void track_keys(input kst_action_t act, input logic [KNUM_W-1:0] knum,
			output key_result_t res[$]);
		key_result_t r;
		kst_event_t kinds [SET_DEPTH];
		int lim;
		int x;
		int c;
		int total;
		int j;
		int hit;
		logic rpt;
		logic held_old;
		res = {};
		lim = (key_limit_reg < MAX_KEYS) ? key_limit_reg : MAX_KEYS;
		r = '0;
		r.pend = ev_total;
		r.tail = 1'b1;
		if (act == ACT_TICK) begin
			rpt = 1'b0;
			total = 0;
			for (j = 0; j < press_order.size(); j++) begin
				x = press_order[j];
				c = m_hold[x];
				held_old = m_held[x];
				if (c < rpt_delay)
					m_hold[x] = CNT_W'(c + 1);
				// once one key reaches the delay the rest of the walk repeats too
				if (c == rpt_delay)
					rpt = 1'b1;
				kinds[j] = (held_old && rpt) ? EV_REPEAT : EV_NONE;
				if ((m_tap[x] || m_held[x] || m_rel[x]) && !idle_mask[x] && total < PEND_MAX)
					total++;
				m_rel[x] = 1'b0;
				if (held_old)
					m_tap[x] = 1'b0;
				if (m_tap[x])
					m_held[x] = 1'b1;
				if (x >= first_nt && rpt) begin
					m_tap[x] = 1'b1;
					m_hold[x] = '0;
				end
			end
			ev_total = PEND_W'(total);
			r.pend = ev_total;
			if (press_order.size() == 0)
				res.push_back(r);
			for (j = 0; j < press_order.size(); j++) begin
				x = press_order[j];
				r.kind = kinds[j];
				r.ekey = KEY_W'(x);
				r.tap = m_tap[x];
				r.held = m_held[x];
				r.rel = m_rel[x];
				r.tail = (j == press_order.size() - 1);
				if (kinds[j] == EV_REPEAT)
					n_repeat++;
				res.push_back(r);
			end
		end else if (act == ACT_NOP || knum == 0 || knum > lim) begin
			n_ignored++;
			res.push_back(r);
		end else begin
			x = knum - 1;
			hit = -1;
			foreach (press_order[k])
				if (press_order[k] == x)
					hit = k;
			if (act == ACT_PRESS) begin
				m_tap[x] = !m_held[x] || (x >= first_nt);
				if (hit < 0) begin
					if (press_order.size() < SET_DEPTH)
						press_order.push_back(KEY_W'(x));
					else
						n_full_press++;
				end
				r.kind = m_tap[x] ? EV_TAP : EV_NONE;
			end else begin
				m_tap[x] = 1'b0;
				m_held[x] = 1'b0;
				m_hold[x] = '0;
				m_rel[x] = 1'b1;
				if (hit >= 0)
					press_order.delete(hit);
				r.kind = EV_RELEASE;
			end
			r.ekey = KEY_W'(x);
			r.tap = m_tap[x];
			r.held = m_held[x];
			r.rel = m_rel[x];
			res.push_back(r);
		end
	endfunction

	function automatic dir_row_t row_pred(input kst_action_t a, input logic [KNUM_W-1:0] k);
		dir_row_t row;
		row = '0;
		row.act = a;
		row.knum = k;
		return row;
	endfunction

	// pending count is still zero in every fixed row
	function automatic dir_row_t row_fixed(input kst_action_t a, input logic [KNUM_W-1:0] k,
			input kst_event_t kind, input logic [KEY_W-1:0] ek, input logic t, input logic h,
			input logic r);
		dir_row_t row;
		row = row_pred(a, k);
		row.fixed = 1'b1;
		row.res.kind = kind;
		row.res.ekey = ek;
		row.res.tap = t;
		row.res.held = h;
		row.res.rel = r;
		row.res.tail = 1'b1;
		return row;
	endfunction

	task automatic send_item(input kst_action_t act, input logic [KNUM_W-1:0] knum,
			input logic fixed, input key_result_t fixed_res);
		key_result_t res_q [$];
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		action <= act;
		key <= knum;
		do @(posedge clk); while (!in_ready);
		n_items++;
		track_keys(act, knum, res_q);
		if (fixed)
			key_event_q.push_back(fixed_res);
		else
			foreach (res_q[k])
				key_event_q.push_back(res_q[k]);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (key_event_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input kst_reg_t r, input logic [63:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		set_reg(r, d);
	endtask

	task automatic load_setting(input logic [7:0] d, input logic [6:0] c, input logic [6:0] nt,
			input logic [63:0] m);
		int lim;
		write_reg(REG_RPT_DLY, d);
		write_reg(REG_KEY_COUNT, c);
		write_reg(REG_FIRST_NONTEXT, nt);
		write_reg(REG_IDLE_MASK, m);
		cfg_valid <= 1'b0;
		n_settings++;
		// keep most keys in a window around the text/non-text boundary
		lim = (c < MAX_KEYS) ? c : MAX_KEYS;
		hot_lo = (nt > 6) ? nt - 5 : 1;
		if (hot_lo + 11 > lim)
			hot_lo = (lim > 12) ? lim - 11 : 1;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			got = {event_kind, event_key, key_tap, key_held, key_released, pending_events, last};
			if (key_event_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("result %0d arrived with none expected: kind %0d key %0d",
						n_results, event_kind, event_key);
			end else begin
				want = key_event_q.pop_front();
				if (got !== want) begin
					n_bad++;
					if (n_bad <= 10) begin
						$display("result %0d: got kind %0d key %0d tap %b held %b rel %b pend %0d last %b",
							n_results, got.kind, got.ekey, got.tap, got.held, got.rel, got.pend,
							got.tail);
						$display("  expected kind %0d key %0d tap %b held %b rel %b pend %0d last %b",
							want.kind, want.ekey, want.tap, want.held, want.rel, want.pend,
							want.tail);
					end
				end
			end
		end
	end

	initial begin : rx_side
		int mode;
		int span;
		int k;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(5, 40);
			for (k = 0; k < span; k++) begin
				if (hold_req && !hold_done) begin
					out_ready <= 1'b0;
					repeat (LONG_HOLD) @(posedge clk);
					hold_done = 1'b1;
				end
				case (mode)
					0, 1: out_ready <= 1'b1;
					2: out_ready <= ($urandom_range(0, 2) != 0);
					default: out_ready <= (k % 4 == 3);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : watchdog
		while (n_cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			n_cycles++;
		end
		$display("no finish after %0d cycles", n_cycles);
		$display("simulation failed");
		$finish;
	end

	initial begin : stim
		kst_action_t act;
		logic [KNUM_W-1:0] knum;
		int p;
		int i;
		int n;
		int roll;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		action <= ACT_PRESS;
		key <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_RPT_DLY;
		cfg_data <= '0;
		foreach (m_tap[k]) begin
			m_tap[k] = 1'b0;
			m_held[k] = 1'b0;
			m_rel[k] = 1'b0;
			m_hold[k] = '0;
		end
		ev_total = '0;
		rpt_delay = 8'd4;
		key_limit_reg = 7'd64;
		first_nt = 7'd64;
		idle_mask = '0;

		dir_tab[0] = row_fixed(ACT_TICK, 7'd0, EV_NONE, 6'd0, 1'b0, 1'b0, 1'b0);
		dir_tab[1] = row_fixed(ACT_PRESS, 7'd0, EV_NONE, 6'd0, 1'b0, 1'b0, 1'b0);
		dir_tab[2] = row_fixed(ACT_PRESS, 7'd127, EV_NONE, 6'd0, 1'b0, 1'b0, 1'b0);
		dir_tab[3] = row_fixed(ACT_NOP, 7'd1, EV_NONE, 6'd0, 1'b0, 1'b0, 1'b0);
		dir_tab[4] = row_fixed(ACT_PRESS, 7'd1, EV_TAP, 6'd0, 1'b1, 1'b0, 1'b0);
		dir_tab[5] = row_fixed(ACT_PRESS, 7'd64, EV_TAP, 6'd63, 1'b1, 1'b0, 1'b0);
		dir_tab[6] = row_fixed(ACT_PRESS, 7'd1, EV_TAP, 6'd0, 1'b1, 1'b0, 1'b0);
		dir_tab[7] = row_fixed(ACT_RELEASE, 7'd30, EV_RELEASE, 6'd29, 1'b0, 1'b0, 1'b1);
		for (i = 8; i < 14; i++)
			dir_tab[i] = row_pred(ACT_TICK, 7'd0);
		// fills the set, the last press finds it full
		for (i = 14; i < 21; i++)
			dir_tab[i] = row_pred(ACT_PRESS, KNUM_W'(i - 12));
		dir_tab[21] = row_pred(ACT_TICK, 7'd0);
		dir_tab[22] = row_pred(ACT_RELEASE, 7'd64);
		dir_tab[23] = row_pred(ACT_RELEASE, 7'd1);
		dir_tab[24] = row_pred(ACT_TICK, 7'd0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_ROWS; i++)
			send_item(dir_tab[i].act, dir_tab[i].knum, dir_tab[i].fixed, dir_tab[i].res);

		for (p = 1; p <= 8; p++) begin
			settle();
			case (p)
				1: load_setting(8'd0, 7'd64, 7'd0, '1);
				2: load_setting(8'd255, 7'd127, 7'd127, '0);
				3: load_setting(8'd1, 7'd0, 7'd64, {$urandom, $urandom});
				default: load_setting(8'($urandom_range(0, 6)), 7'($urandom_range(8, 64)),
					7'($urandom_range(0, 64)), {$urandom, $urandom});
			endcase
			n = (p == 3) ? 8 : ((p <= 2) ? 40 : 32);
			for (i = 0; i < n; i++) begin
				if (p == 4 && i == 10)
					hold_req = 1'b1;
				roll = $urandom_range(0, 99);
				if (roll < 35)
					act = ACT_PRESS;
				else if (roll < 57)
					act = ACT_RELEASE;
				else if (roll < 95)
					act = ACT_TICK;
				else
					act = ACT_NOP;
				roll = $urandom_range(0, 99);
				if (roll < 70)
					knum = KNUM_W'(hot_lo + $urandom_range(0, 11));
				else if (roll < 85)
					knum = KNUM_W'($urandom_range(1, 64));
				else if (roll < 95)
					knum = ($urandom_range(0, 1) != 0) ? 7'd0 : 7'($urandom_range(65, 127));
				else
					knum = KNUM_W'($urandom);
				send_item(act, knum, 1'b0, '0);
			end
		end
		settle();
		repeat (20) @(posedge clk);

		$display("covered %0d items under %0d register settings, %0d results checked",
			n_items, n_settings, n_results);
		$display("held repeats %0d, presses into a full set %0d, ignored items %0d",
			n_repeat, n_full_press, n_ignored);
		if (n_bad == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
